>>> hw/rtl/gasp_pkg.sv
package gasp_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int COORD_W = 6;
  localparam int INDEX_W = 12;
  localparam int LEN_W = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 7;

  // Step costs of the 8-connected move set.
  localparam int STEP_STRAIGHT = 10;
  localparam int STEP_DIAG = 14;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_SPARE = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FOUND = 2'd1,
    STAT_NONE  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ROW   = 3'd0,
    CFG_START_COL   = 3'd1,
    CFG_GOAL_ROW    = 3'd2,
    CFG_GOAL_COL    = 3'd3,
    CFG_ROWS_IN_USE = 3'd4,
    CFG_COLS_IN_USE = 3'd5
  } cfg_reg_e;

  // Row and column offsets of the eight directions. Direction d and 7 - d are opposite.
  localparam logic signed [1:0] DIR_ROW [8] = '{
    -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1
  };
  localparam logic signed [1:0] DIR_COL [8] = '{
    -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1
  };

  typedef struct packed {
    command_e             command;
    logic [COORD_W-1:0]   cell_row;
    logic [COORD_W-1:0]   cell_col;
    logic                 blocked;
    logic [INDEX_W-1:0]   path_index;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [LEN_W-1:0]     path_length;
    logic [COORD_W-1:0]   path_row;
    logic [COORD_W-1:0]   path_col;
  } out_item_t;

  // Operations the controller asks of the datapath in each cycle.
  typedef struct packed {
    logic occ_clr;
    logic capture;
    logic load_wr;
    logic res_ack;
    logic read_issue;
    logic res_read;
    logic run_init;
    logic res_nopath;
    logic clr_wr;
    logic start_wr;
    logic scan_init;
    logic scan_step;
    logic cur_close;
    logic nb_read;
    logic nb_heur;
    logic nb_write;
    logic dir_inc;
    logic walk_init;
    logic walk_read;
    logic walk_step_n;
    logic walk2_init;
    logic path_wr;
    logic walk_step_k;
    logic res_found;
    logic out_load;
  } dp_cmd_t;

  // Conditions the datapath reports back to the controller.
  typedef struct packed {
    command_e command;
    logic     occ_clear_last;
    logic     out_of_area;
    logic     clear_last;
    logic     heur_done;
    logic     scan_last;
    logic     best_found;
    logic     best_is_goal;
    logic     nb_in_range;
    logic     nb_update;
    logic     dir_last;
    logic     walk_at_start;
    logic     k_is_one;
    logic     out_free;
  } dp_stat_t;

  function automatic logic is_diag(logic [2:0] d);
    return (DIR_ROW[d] != 2'sd0) && (DIR_COL[d] != 2'sd0);
  endfunction

endpackage

>>> hw/rtl/gasp_heur.sv
// Heuristic unit: floor of the Euclidean distance to the goal, one root bit pair per cycle.
module gasp_heur
  import gasp_pkg::*;
#(
  parameter int PosW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [PosW-1:0] row_i,
  input  logic [PosW-1:0] col_i,
  input  logic [PosW-1:0] goal_row_i,
  input  logic [PosW-1:0] goal_col_i,
  output logic            done_o,
  output logic [PosW:0]   h_o
);

  localparam int SqW = 2 * PosW + 2;
  localparam logic [SqW-1:0] TopBit = SqW'(1) << (SqW - 2);

  logic [PosW-1:0]   dr_q, dc_q;
  logic [2*PosW-1:0] sq_r, sq_c;
  logic [SqW-1:0]    sq_sum;
  logic [SqW-1:0]    rem_q, root_q, bit_q;
  logic [SqW:0]      trial;
  logic              sq_pend_q, busy_q, done_q;

  // Sum of squares of the absolute offsets.
  assign sq_r = {{PosW{1'b0}}, dr_q} * {{PosW{1'b0}}, dr_q};
  assign sq_c = {{PosW{1'b0}}, dc_q} * {{PosW{1'b0}}, dc_q};
  assign sq_sum = SqW'(sq_r) + SqW'(sq_c);
  assign trial = {1'b0, root_q} + {1'b0, bit_q};

  // Sequencing flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_pend_q <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      sq_pend_q <= 1'b1;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (sq_pend_q) begin
      sq_pend_q <= 1'b0;
      busy_q <= 1'b1;
    end else if (busy_q && (bit_q == '0)) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end
  end

  // Offsets, squares and the digit-by-digit square root.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dr_q <= (row_i >= goal_row_i) ? row_i - goal_row_i : goal_row_i - row_i;
      dc_q <= (col_i >= goal_col_i) ? col_i - goal_col_i : goal_col_i - col_i;
    end else if (sq_pend_q) begin
      rem_q <= sq_sum;
      root_q <= '0;
      bit_q <= TopBit;
    end else if (busy_q && (bit_q != '0)) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q <= SqW'({1'b0, rem_q} - trial);
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign h_o = (PosW + 1)'(root_q);

endmodule

>>> hw/rtl/gasp_dp.sv
// Datapath: configuration, grid memories, open-set scan, expansion and path trace.
module gasp_dp
  import gasp_pkg::*;
#(
  parameter int MaxRows = 64,
  parameter int MaxCols = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_data_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output out_item_t             out_data_o
);

  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam int AddrW = RowW + ColW;
  localparam int Depth = 1 << AddrW;
  localparam int CntW = AddrW + 1;
  localparam int PosA = (RowW > ColW) ? RowW : ColW;
  localparam int PosW = (PosA > COORD_W) ? PosA : COORD_W;
  localparam int CostW = $clog2(MaxRows * MaxCols * STEP_DIAG + 1);
  localparam int EstW = CostW + 1;

  typedef struct packed {
    logic             open;
    logic             closed;
    logic [2:0]       par;
    logic [CostW-1:0] g;
    logic [EstW-1:0]  f;
  } node_t;

  localparam node_t NodeClear = '{open: 1'b0, closed: 1'b0, par: 3'd0, g: '1, f: '1};

  // Configuration registers.
  logic [COORD_W-1:0]    start_row_q, start_col_q, goal_row_q, goal_col_q;
  logic [CFG_DATA_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_row_q <= '0;
      start_col_q <= '0;
      goal_row_q <= '0;
      goal_col_q <= '0;
      rows_q <= CFG_DATA_W'(64);
      cols_q <= CFG_DATA_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_ROW:   start_row_q <= COORD_W'(cfg_data_i);
        CFG_START_COL:   start_col_q <= COORD_W'(cfg_data_i);
        CFG_GOAL_ROW:    goal_row_q <= COORD_W'(cfg_data_i);
        CFG_GOAL_COL:    goal_col_q <= COORD_W'(cfg_data_i);
        CFG_ROWS_IN_USE: rows_q <= cfg_data_i;
        CFG_COLS_IN_USE: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Area in use: zero counts as one, anything above the grid counts as the grid.
  logic [RowW:0]   rows_eff;
  logic [ColW:0]   cols_eff;
  logic [RowW-1:0] rows_last, start_r, goal_r;
  logic [ColW-1:0] cols_last, start_c, goal_c;

  always_comb begin
    if (rows_q == '0) begin
      rows_eff = (RowW + 1)'(1);
    end else if (int'(rows_q) > MaxRows) begin
      rows_eff = (RowW + 1)'(MaxRows);
    end else begin
      rows_eff = (RowW + 1)'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = (ColW + 1)'(1);
    end else if (int'(cols_q) > MaxCols) begin
      cols_eff = (ColW + 1)'(MaxCols);
    end else begin
      cols_eff = (ColW + 1)'(cols_q);
    end
  end

  assign rows_last = RowW'(rows_eff - 1'b1);
  assign cols_last = ColW'(cols_eff - 1'b1);
  assign start_r = RowW'(start_row_q);
  assign start_c = ColW'(start_col_q);
  assign goal_r = RowW'(goal_row_q);
  assign goal_c = ColW'(goal_col_q);

  // Captured input transaction.
  in_item_t in_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_data_i;
  end

  // Control registers of the datapath.
  logic              pend_q, best_found_q, out_valid_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   walk_n_q, walk_k_q;
  logic [AddrW-1:0]  occ_clr_q;
  out_item_t         res_q, out_q;

  // Working registers.
  logic [AddrW-1:0]  clr_addr_q;
  logic [RowW-1:0]   scan_r_q, pend_r_q, best_r_q, cur_r_q, nb_r_q, walk_r_q;
  logic [ColW-1:0]   scan_c_q, pend_c_q, best_c_q, cur_c_q, nb_c_q, walk_c_q;
  logic [CostW-1:0]  best_g_q, cur_g_q, t_q;
  logic [EstW-1:0]   best_f_q;
  logic [2:0]        best_par_q, dir_q;

  // Memories and their registered read data.
  logic              occ_mem [Depth];
  node_t             node_mem [Depth];
  logic [AddrW-1:0]  path_mem [Depth];
  logic              occ_rd_q;
  node_t             node_rd_q;
  logic [AddrW-1:0]  path_rd_q;

  // Heuristic unit, fed with the start cell or the neighbor under update.
  logic              heur_start, heur_done;
  logic [PosW-1:0]   heur_row, heur_col;
  logic [PosW:0]     heur_h;

  assign heur_start = cmd_i.run_init | cmd_i.nb_heur;
  assign heur_row = cmd_i.run_init ? PosW'(start_row_q) : PosW'(nb_r_q);
  assign heur_col = cmd_i.run_init ? PosW'(start_col_q) : PosW'(nb_c_q);

  gasp_heur #(
    .PosW(PosW)
  ) u_heur (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (heur_start),
    .row_i      (heur_row),
    .col_i      (heur_col),
    .goal_row_i (PosW'(goal_row_q)),
    .goal_col_i (PosW'(goal_col_q)),
    .done_o     (heur_done),
    .h_o        (heur_h)
  );

  // Neighbor of the current cell in the direction under test.
  logic signed [RowW+1:0] nb_rs;
  logic signed [ColW+1:0] nb_cs;
  logic                   nb_in_range;
  logic [CostW:0]         t_calc;
  logic [2:0]             walk_par;

  assign nb_rs = $signed({2'b00, cur_r_q}) + DIR_ROW[dir_q];
  assign nb_cs = $signed({2'b00, cur_c_q}) + DIR_COL[dir_q];
  assign nb_in_range = (nb_rs >= 0) && (nb_rs < $signed({1'b0, rows_eff}))
                    && (nb_cs >= 0) && (nb_cs < $signed({1'b0, cols_eff}));
  assign t_calc = {1'b0, cur_g_q}
                + (is_diag(dir_q) ? (CostW + 1)'(STEP_DIAG) : (CostW + 1)'(STEP_STRAIGHT));
  assign walk_par = node_rd_q.par;

  // Node memory write and read port selection.
  logic             node_we, node_re;
  logic [AddrW-1:0] node_waddr, node_raddr;
  node_t            node_wdata;

  always_comb begin
    node_we = 1'b1;
    node_waddr = clr_addr_q;
    node_wdata = NodeClear;
    priority if (cmd_i.clr_wr) begin
      node_waddr = clr_addr_q;
      node_wdata = NodeClear;
    end else if (cmd_i.start_wr) begin
      node_waddr = {start_r, start_c};
      node_wdata = '{open: 1'b1, closed: 1'b0, par: 3'd0, g: '0, f: EstW'(heur_h)};
    end else if (cmd_i.cur_close) begin
      node_waddr = {best_r_q, best_c_q};
      node_wdata = '{open: 1'b0, closed: 1'b1, par: best_par_q, g: best_g_q, f: best_f_q};
    end else if (cmd_i.nb_write) begin
      node_waddr = {nb_r_q, nb_c_q};
      node_wdata = '{open: 1'b1, closed: 1'b0, par: 3'd7 - dir_q, g: t_q,
                     f: EstW'({1'b0, t_q} + EstW'(heur_h))};
    end else begin
      node_we = 1'b0;
    end

    node_re = 1'b1;
    priority if (cmd_i.scan_step) begin
      node_raddr = {scan_r_q, scan_c_q};
    end else if (cmd_i.nb_read) begin
      node_raddr = {RowW'(nb_rs), ColW'(nb_cs)};
    end else if (cmd_i.walk_read) begin
      node_raddr = {walk_r_q, walk_c_q};
    end else begin
      node_re = 1'b0;
      node_raddr = {walk_r_q, walk_c_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    if (node_re) node_rd_q <= node_mem[node_raddr];
  end

  // Occupancy memory: cleared after reset, loaded by transactions, read for each neighbor in range.
  always_ff @(posedge clk_i) begin
    if (cmd_i.occ_clr) begin
      occ_mem[occ_clr_q] <= 1'b0;
    end else if (cmd_i.load_wr && (int'(in_q.cell_row) < MaxRows)
                 && (int'(in_q.cell_col) < MaxCols)) begin
      occ_mem[{RowW'(in_q.cell_row), ColW'(in_q.cell_col)}] <= in_q.blocked;
    end
    if (cmd_i.nb_read) occ_rd_q <= occ_mem[{RowW'(nb_rs), ColW'(nb_cs)}];
  end

  // Path memory: written during the trace, read by read transactions.
  always_ff @(posedge clk_i) begin
    if (cmd_i.path_wr) path_mem[AddrW'(walk_k_q - 1'b1)] <= {walk_r_q, walk_c_q};
    if (cmd_i.read_issue) path_rd_q <= path_mem[AddrW'(in_q.path_index)];
  end

  // Control state: scan pending flag, best candidate flag, path count, output slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      best_found_q <= 1'b0;
      count_q <= '0;
      out_valid_q <= 1'b0;
      occ_clr_q <= '0;
    end else begin
      pend_q <= cmd_i.scan_step;
      if (cmd_i.occ_clr) occ_clr_q <= occ_clr_q + 1'b1;
      if (cmd_i.scan_init) begin
        best_found_q <= 1'b0;
      end else if (pend_q && node_rd_q.open) begin
        best_found_q <= 1'b1;
      end
      if (cmd_i.run_init) begin
        count_q <= '0;
      end else if (cmd_i.res_found) begin
        count_q <= walk_n_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the search and the trace.
  always_ff @(posedge clk_i) begin
    // Clearing sweep over the node memory.
    if (cmd_i.run_init) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end

    // Row-major scan of the area in use.
    if (cmd_i.scan_init) begin
      scan_r_q <= '0;
      scan_c_q <= '0;
    end else if (cmd_i.scan_step) begin
      pend_r_q <= scan_r_q;
      pend_c_q <= scan_c_q;
      if (scan_c_q == cols_last) begin
        scan_c_q <= '0;
        scan_r_q <= scan_r_q + 1'b1;
      end else begin
        scan_c_q <= scan_c_q + 1'b1;
      end
    end

    // The first open cell of lowest estimate wins.
    if (pend_q && node_rd_q.open && (!best_found_q || (node_rd_q.f < best_f_q))) begin
      best_r_q <= pend_r_q;
      best_c_q <= pend_c_q;
      best_g_q <= node_rd_q.g;
      best_f_q <= node_rd_q.f;
      best_par_q <= node_rd_q.par;
    end

    // Expansion of the chosen cell.
    if (cmd_i.cur_close) begin
      cur_r_q <= best_r_q;
      cur_c_q <= best_c_q;
      cur_g_q <= best_g_q;
      dir_q <= '0;
    end else if (cmd_i.dir_inc) begin
      dir_q <= dir_q + 1'b1;
    end
    if (cmd_i.nb_read) begin
      nb_r_q <= RowW'(nb_rs);
      nb_c_q <= ColW'(nb_cs);
    end
    if (cmd_i.nb_heur) t_q <= CostW'(t_calc);

    // Trace from the goal back to the start, first counting, then storing.
    if (cmd_i.walk_init || cmd_i.walk2_init) begin
      walk_r_q <= goal_r;
      walk_c_q <= goal_c;
    end else if (cmd_i.walk_step_n || cmd_i.walk_step_k) begin
      walk_r_q <= RowW'($signed({1'b0, walk_r_q}) + DIR_ROW[walk_par]);
      walk_c_q <= ColW'($signed({1'b0, walk_c_q}) + DIR_COL[walk_par]);
    end
    if (cmd_i.walk_init) begin
      walk_n_q <= CntW'(1);
    end else if (cmd_i.walk_step_n) begin
      walk_n_q <= walk_n_q + 1'b1;
    end
    if (cmd_i.walk2_init) begin
      walk_k_q <= walk_n_q;
    end else if (cmd_i.walk_step_k) begin
      walk_k_q <= walk_k_q - 1'b1;
    end
  end

  // Result of the current transaction, then the output register.
  logic read_ok;
  assign read_ok = int'(in_q.path_index) < int'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ack) begin
      res_q <= '{status: STAT_OK, path_length: LEN_W'(count_q), path_row: '0, path_col: '0};
    end else if (cmd_i.res_nopath) begin
      res_q <= '{status: STAT_NONE, path_length: '0, path_row: '0, path_col: '0};
    end else if (cmd_i.res_found) begin
      res_q <= '{status: STAT_FOUND, path_length: LEN_W'(walk_n_q), path_row: '0,
                 path_col: '0};
    end else if (cmd_i.res_read) begin
      if (read_ok) begin
        res_q <= '{status: STAT_OK, path_length: LEN_W'(count_q),
                   path_row: COORD_W'(path_rd_q[AddrW-1:ColW]),
                   path_col: COORD_W'(path_rd_q[ColW-1:0])};
      end else begin
        res_q <= '{status: STAT_NONE, path_length: LEN_W'(count_q), path_row: '0,
                   path_col: '0};
      end
    end
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // Status toward the controller.
  always_comb begin
    stat_o.command = in_q.command;
    stat_o.occ_clear_last = &occ_clr_q;
    stat_o.out_of_area = (int'(start_row_q) >= int'(rows_eff))
                      || (int'(start_col_q) >= int'(cols_eff))
                      || (int'(goal_row_q) >= int'(rows_eff))
                      || (int'(goal_col_q) >= int'(cols_eff));
    stat_o.clear_last = &clr_addr_q;
    stat_o.heur_done = heur_done;
    stat_o.scan_last = (scan_r_q == rows_last) && (scan_c_q == cols_last);
    stat_o.best_found = best_found_q;
    stat_o.best_is_goal = (best_r_q == goal_r) && (best_c_q == goal_c);
    stat_o.nb_in_range = nb_in_range;
    stat_o.nb_update = !occ_rd_q && !node_rd_q.closed && (t_calc < {1'b0, node_rd_q.g});
    stat_o.dir_last = &dir_q;
    stat_o.walk_at_start = (walk_r_q == start_r) && (walk_c_q == start_c);
    stat_o.k_is_one = (walk_k_q == CntW'(1));
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

endmodule

>>> hw/rtl/gasp_ctrl.sv
// Controller: sequences each transaction through the datapath.
module gasp_ctrl
  import gasp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [18:0] {
    S_IDLE       = 19'h00001,
    S_DISPATCH   = 19'h00002,
    S_READ_WAIT  = 19'h00004,
    S_CLEAR      = 19'h00008,
    S_INIT_START = 19'h00010,
    S_SCAN_PREP  = 19'h00020,
    S_SCAN       = 19'h00040,
    S_SCAN_END   = 19'h00080,
    S_DECIDE     = 19'h00100,
    S_NB_ADDR    = 19'h00200,
    S_NB_EVAL    = 19'h00400,
    S_NB_HEUR    = 19'h00800,
    S_NB_NEXT    = 19'h01000,
    S_WALK_CHK   = 19'h02000,
    S_WALK_STEP  = 19'h04000,
    S_PATH_WR    = 19'h08000,
    S_PATH_STEP  = 19'h10000,
    S_RESP       = 19'h20000,
    S_OCC_CLEAR  = 19'h40000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_OCC_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath operations.
  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    unique case (state_q)
      S_OCC_CLEAR: begin
        cmd_o.occ_clr = 1'b1;
        if (stat_i.occ_clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.command)
          CMD_LOAD: begin
            cmd_o.load_wr = 1'b1;
            cmd_o.res_ack = 1'b1;
            state_d = S_RESP;
          end
          CMD_READ: begin
            cmd_o.read_issue = 1'b1;
            state_d = S_READ_WAIT;
          end
          CMD_RUN: begin
            cmd_o.run_init = 1'b1;
            if (stat_i.out_of_area) begin
              cmd_o.res_nopath = 1'b1;
              state_d = S_RESP;
            end else begin
              state_d = S_CLEAR;
            end
          end
          CMD_SPARE: begin
            cmd_o.res_ack = 1'b1;
            state_d = S_RESP;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_READ_WAIT: begin
        cmd_o.res_read = 1'b1;
        state_d = S_RESP;
      end
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clear_last) state_d = S_INIT_START;
      end
      S_INIT_START: begin
        if (stat_i.heur_done) begin
          cmd_o.start_wr = 1'b1;
          state_d = S_SCAN_PREP;
        end
      end
      S_SCAN_PREP: begin
        cmd_o.scan_init = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = S_SCAN_END;
      end
      S_SCAN_END: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat_i.best_found) begin
          cmd_o.res_nopath = 1'b1;
          state_d = S_RESP;
        end else if (stat_i.best_is_goal) begin
          cmd_o.walk_init = 1'b1;
          state_d = S_WALK_CHK;
        end else begin
          cmd_o.cur_close = 1'b1;
          state_d = S_NB_ADDR;
        end
      end
      S_NB_ADDR: begin
        if (stat_i.nb_in_range) begin
          cmd_o.nb_read = 1'b1;
          state_d = S_NB_EVAL;
        end else begin
          state_d = S_NB_NEXT;
        end
      end
      S_NB_EVAL: begin
        if (stat_i.nb_update) begin
          cmd_o.nb_heur = 1'b1;
          state_d = S_NB_HEUR;
        end else begin
          state_d = S_NB_NEXT;
        end
      end
      S_NB_HEUR: begin
        if (stat_i.heur_done) begin
          cmd_o.nb_write = 1'b1;
          state_d = S_NB_NEXT;
        end
      end
      S_NB_NEXT: begin
        cmd_o.dir_inc = 1'b1;
        state_d = stat_i.dir_last ? S_SCAN_PREP : S_NB_ADDR;
      end
      S_WALK_CHK: begin
        if (stat_i.walk_at_start) begin
          cmd_o.walk2_init = 1'b1;
          state_d = S_PATH_WR;
        end else begin
          cmd_o.walk_read = 1'b1;
          state_d = S_WALK_STEP;
        end
      end
      S_WALK_STEP: begin
        cmd_o.walk_step_n = 1'b1;
        state_d = S_WALK_CHK;
      end
      S_PATH_WR: begin
        cmd_o.path_wr = 1'b1;
        if (stat_i.k_is_one) begin
          cmd_o.res_found = 1'b1;
          state_d = S_RESP;
        end else begin
          cmd_o.walk_read = 1'b1;
          state_d = S_PATH_STEP;
        end
      end
      S_PATH_STEP: begin
        cmd_o.walk_step_k = 1'b1;
        state_d = S_PATH_WR;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> hw/rtl/grid_astar_path_search.sv
// A* path search over an occupancy grid of up to MaxRows x MaxCols cells, 8-connected with
// straight steps costing 10 and diagonal steps 14. Each input transaction is one command and
// yields exactly one result transaction. After reset the block clears all entries of its
// occupancy memory, 2^(clog2(MaxRows)+clog2(MaxCols)) (4096 at the default size), and stalls
// its input until that is done. A load or an unused command passes the dispatch and response
// states, a path read also a read wait state, and each may wait for the output register. A
// run first clears all 2^(clog2(MaxRows)+clog2(MaxCols)) node memory entries (4096 at the
// default size), then for every expanded cell scans all R x C cells of the area in use, one
// node memory read per cycle, and tests its eight neighbors, running the iterative square-root
// unit for each improved neighbor. The node memory, with one read and one write port, sets the
// pace; the trace walks the path twice, first counting, then storing. The grid is loaded while
// idle; configuration must be written only while idle, which the block itself does not enforce.
module grid_astar_path_search
  import gasp_pkg::*;
#(
  parameter int MaxRows = 64,
  parameter int MaxCols = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gasp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  gasp_dp #(
    .MaxRows(MaxRows),
    .MaxCols(MaxCols)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/gasp_checker.sv
// Port-level checks of the path search block.
module gasp_checker
  import gasp_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input in_item_t              in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_item_t             out_data_o
);

  // The block works on one transaction at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a transaction is still in work");

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A found path holds at least the start cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_FOUND) |-> out_data_o.path_length != '0)
    else $error("path found with zero length");

  // A refused read or run carries no cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_NONE)
      |-> (out_data_o.path_row == '0) && (out_data_o.path_col == '0))
    else $error("cell reported with a negative status");

endmodule

bind grid_astar_path_search gasp_checker u_checker (.*);

>>> tb/sv/grid_astar_path_search_tb.sv
module grid_astar_path_search_tb;
  import gasp_pkg::*;

  // Path predictor and store of expected result transactions.
  class path_scoreboard;
    bit              occ [4096];
    int unsigned     g_cost [4096];
    int unsigned     f_cost [4096];
    bit [2:0]        par_dir [4096];
    bit              is_open [4096];
    bit              is_closed [4096];
    bit [11:0]       path_cell [4096];
    bit [12:0]       path_count;
    bit [5:0]        s_row, s_col, g_row, g_col;
    bit [6:0]        n_rows, n_cols;
    out_item_t       expected_q [$];
    int              errors;

    function new();
      foreach (occ[i]) occ[i] = 1'b0;
      path_count = '0;
      s_row = '0; s_col = '0; g_row = '0; g_col = '0;
      n_rows = 7'd64; n_cols = 7'd64;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, bit [6:0] val);
      case (idx)
        CFG_START_ROW:   s_row = val[5:0];
        CFG_START_COL:   s_col = val[5:0];
        CFG_GOAL_ROW:    g_row = val[5:0];
        CFG_GOAL_COL:    g_col = val[5:0];
        CFG_ROWS_IN_USE: n_rows = val;
        CFG_COLS_IN_USE: n_cols = val;
        default: ;
      endcase
    endfunction

    function int unsigned dist_floor(int r, int c);
      int unsigned s;
      int unsigned q;
      s = (r - g_row) * (r - g_row) + (c - g_col) * (c - g_col);
      q = 0;
      while ((q + 1) * (q + 1) <= s) q++;
      return q;
    endfunction

    function int clamp_size(bit [6:0] v);
      if (v == 0) return 1;
      if (v > 64) return 64;
      return v;
    endfunction

    // Runs the search and returns the status of the run.
    function status_e search();
      int dr [8];
      int dc [8];
      int nr, nc, br, bc, r, c, d, k, cur, wr, wc, n, p;
      int unsigned bf, t;
      dr = '{-1, -1, -1, 0, 0, 1, 1, 1};
      dc = '{-1, 0, 1, -1, 1, -1, 0, 1};
      nr = clamp_size(n_rows);
      nc = clamp_size(n_cols);
      path_count = '0;
      if (s_row >= nr || s_col >= nc || g_row >= nr || g_col >= nc) return STAT_NONE;
      for (int i = 0; i < 4096; i++) begin
        g_cost[i] = '1; f_cost[i] = '1; is_open[i] = 0; is_closed[i] = 0;
      end
      g_cost[s_row * 64 + s_col] = 0;
      f_cost[s_row * 64 + s_col] = dist_floor(s_row, s_col);
      is_open[s_row * 64 + s_col] = 1;
      forever begin
        br = -1; bc = -1; bf = '1;
        for (r = 0; r < nr; r++)
          for (c = 0; c < nc; c++) begin
            k = r * 64 + c;
            if (is_open[k] && (br < 0 || f_cost[k] < bf)) begin
              bf = f_cost[k]; br = r; bc = c;
            end
          end
        if (br < 0) return STAT_NONE;
        if (br == g_row && bc == g_col) begin
          // Trace back once to count cells, then again to store them start first.
          n = 1; wr = g_row; wc = g_col;
          while ((wr != s_row || wc != s_col) && n < 4096) begin
            p = par_dir[wr * 64 + wc];
            wr += dr[p]; wc += dc[p]; n++;
          end
          wr = g_row; wc = g_col;
          for (k = n; k > 0; k--) begin
            path_cell[k - 1] = wr * 64 + wc;
            p = par_dir[wr * 64 + wc];
            if (k > 1) begin
              wr += dr[p]; wc += dc[p];
            end
          end
          path_count = n;
          return STAT_FOUND;
        end
        cur = br * 64 + bc;
        is_open[cur] = 0;
        is_closed[cur] = 1;
        for (d = 0; d < 8; d++) begin
          r = br + dr[d]; c = bc + dc[d];
          if (r < 0 || r >= nr || c < 0 || c >= nc) continue;
          k = r * 64 + c;
          if (occ[k] || is_closed[k]) continue;
          t = g_cost[cur] + ((dr[d] != 0 && dc[d] != 0) ? 14 : 10);
          if (t < g_cost[k]) begin
            g_cost[k] = t;
            f_cost[k] = t + dist_floor(r, c);
            par_dir[k] = 7 - d;
            is_open[k] = 1;
          end
        end
      end
    endfunction

    // Notes an accepted input transaction and queues its expected result.
    function void note(in_item_t it);
      out_item_t res;
      res = '0;
      res.status = STAT_OK;
      case (it.command)
        CMD_LOAD: occ[{it.cell_row, it.cell_col}] = it.blocked;
        CMD_RUN:  res.status = search();
        CMD_READ: begin
          if (it.path_index < path_count) begin
            res.path_row = path_cell[it.path_index][11:6];
            res.path_col = path_cell[it.path_index][5:0];
          end else begin
            res.status = STAT_NONE;
          end
        end
        default: ;
      endcase
      res.path_length = path_count;
      expected_q.push_back(res);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // Checks an accepted result transaction against the oldest expectation.
    task check(out_item_t got);
      out_item_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.status !== exp_res.status)
        report($sformatf("status %0d, expected %0d", got.status, exp_res.status));
      if (got.path_length !== exp_res.path_length)
        report($sformatf("path_length %0d, expected %0d", got.path_length,
                         exp_res.path_length));
      if (got.path_row !== exp_res.path_row)
        report($sformatf("path_row %0d, expected %0d", got.path_row, exp_res.path_row));
      if (got.path_col !== exp_res.path_col)
        report($sformatf("path_col %0d, expected %0d", got.path_col, exp_res.path_col));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;

  path_scoreboard sb;
  bit quiet;
  bit hold_req;

  grid_astar_path_search uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(out_data_o);
  end

  // Receiver stall: random bursts, one long hold-off on request, none when quiet.
  initial begin : receiver
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        for (n = 0; n < 400; n++) @(posedge clk_i);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #200000000;
    $display("grid_astar_path_search_tb failed");
    $finish;
  end

  task send(in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note(it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task send_cmd(command_e cmd, int row, int col, bit blk, int idx);
    in_item_t it;
    it.command = cmd;
    it.cell_row = row;
    it.cell_col = col;
    it.blocked = blk;
    it.path_index = idx;
    send(it);
  endtask

  task write_reg(cfg_reg_e idx, bit [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task set_search(int sr, int sc, int gr, int gc, int nr, int nc);
    write_reg(CFG_START_ROW, sr);
    write_reg(CFG_START_COL, sc);
    write_reg(CFG_GOAL_ROW, gr);
    write_reg(CFG_GOAL_COL, gc);
    write_reg(CFG_ROWS_IN_USE, nr);
    write_reg(CFG_COLS_IN_USE, nc);
  endtask

  // Waits until every expected result has arrived, then lets the block settle.
  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int nr, nc, sel, top;
    sb = new();
    quiet = 0;
    hold_req = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reads before any run, start equal to goal on the full grid, spare command.
    send_cmd(CMD_READ, 0, 0, 0, 0);
    send_cmd(CMD_READ, 63, 63, 1, 4095);
    send_cmd(CMD_LOAD, 63, 63, 1, 4095);
    send_cmd(CMD_LOAD, 0, 0, 1, 0);
    send_cmd(CMD_RUN, 0, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 1);
    send_cmd(CMD_SPARE, 63, 63, 1, 4095);
    send_cmd(CMD_LOAD, 0, 0, 0, 0);
    drain();

    // Zero rows counts as one, oversized columns as the maximum.
    set_search(0, 5, 0, 9, 0, 127);
    send_cmd(CMD_RUN, 0, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 4);
    send_cmd(CMD_READ, 0, 0, 0, 5);
    drain();

    // Blocked goal, blocked start and a goal outside the area.
    set_search(0, 0, 3, 3, 4, 4);
    send_cmd(CMD_LOAD, 3, 3, 1, 0);
    send_cmd(CMD_RUN, 0, 0, 0, 0);
    send_cmd(CMD_LOAD, 3, 3, 0, 0);
    send_cmd(CMD_LOAD, 0, 0, 1, 0);
    send_cmd(CMD_RUN, 0, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 3);
    send_cmd(CMD_LOAD, 0, 0, 0, 0);
    drain();
    set_search(63, 0, 63, 63, 4, 4);
    send_cmd(CMD_RUN, 0, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 0);
    drain();

    // Random phases on small areas; the last one runs without idling.
    for (int ph = 0; ph < 9; ph++) begin
      nr = $urandom_range(1, 8);
      nc = $urandom_range(1, 8);
      if ($urandom_range(0, 7) == 0)
        set_search($urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, nr - 1), $urandom_range(0, nc - 1), nr, nc);
      else
        set_search($urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                   $urandom_range(0, nr - 1), $urandom_range(0, nc - 1), nr, nc);
      if (ph == 2) hold_req = 1;
      if (ph == 8) quiet = 1;
      for (int it = 0; it < 7; it++) begin
        sel = $urandom_range(0, 99);
        if (ph == 2 && it < 8) sel = 0;
        if (sel < 55) begin
          if ($urandom_range(0, 4) == 0)
            send_cmd(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1), $urandom_range(0, 4095));
          else
            send_cmd(CMD_LOAD, $urandom_range(0, 9), $urandom_range(0, 9),
                     $urandom_range(0, 2) == 0, $urandom_range(0, 4095));
        end else if (sel < 72) begin
          send_cmd(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 1), $urandom_range(0, 4095));
        end else if (sel < 95) begin
          top = sb.path_count + 1;
          if ($urandom_range(0, 5) == 0)
            send_cmd(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1), $urandom_range(0, 4095));
          else
            send_cmd(CMD_READ, 0, 0, 0, $urandom_range(0, top));
        end else begin
          send_cmd(CMD_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 1), $urandom_range(0, 4095));
        end
      end
      send_cmd(CMD_RUN, 0, 0, 0, 0);
      send_cmd(CMD_READ, 0, 0, 0, 0);
      drain();
    end

    if (sb.errors == 0) begin
      $display("grid_astar_path_search_tb passed");
    end else begin
      $display("grid_astar_path_search_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gasp_pkg.sv
hw/rtl/gasp_heur.sv
hw/rtl/gasp_dp.sv
hw/rtl/gasp_ctrl.sv
hw/rtl/grid_astar_path_search.sv
hw/rtl/gasp_checker.sv
tb/sv/grid_astar_path_search_tb.sv
